/* rtl/duration_string_to_minutes_macros.svh */
// assertion macros for the duration parser
`ifndef DURATION_STRING_TO_MINUTES_MACROS_SVH
`define DURATION_STRING_TO_MINUTES_MACROS_SVH

// same-cycle implication, checked at every clk edge outside reset
`define DSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("duration parser check failed");

// next-cycle implication, checked at every clk edge outside reset
`define DSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("duration parser check failed");

`endif

/* rtl/dsm_pkg.sv */
// types, constants and arithmetic helpers of the duration parser
package dsm_pkg;

    localparam int CHAR_W = 8;
    localparam int WORD_W = 32;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WORD_W+3:0] acc_wide_t;

    // ascii codes the parser reacts to
    localparam char_t CH_0 = 8'h30;
    localparam char_t CH_9 = 8'h39;
    localparam char_t CH_P = 8'h50;
    localparam char_t CH_T = 8'h54;
    localparam char_t CH_M = 8'h4D;
    localparam char_t CH_D = 8'h44;
    localparam char_t CH_H = 8'h48;
    localparam char_t CH_S = 8'h53;

    // reciprocal of 60: q = (x * RECIP_60) >> RECIP_60_SHIFT, exact for 32-bit x
    localparam word_t RECIP_60       = 32'h8888_8889;
    localparam int    RECIP_60_SHIFT = 37;

    // snapshot of one finished string, ready for the final sum
    typedef struct packed {
        word_t day_min;
        word_t hour_min;
        word_t minutes;
        word_t sec_min;
        logic  err;
    } fin_t;

    // x * 1440 modulo 2^32, as 1024 + 256 + 128 + 32
    function automatic word_t times1440(input word_t x);
        return (x << 10) + (x << 8) + (x << 7) + (x << 5);
    endfunction

    // x * 60 modulo 2^32, as 64 - 4
    function automatic word_t times60(input word_t x);
        return (x << 6) - (x << 2);
    endfunction

    // x / 60 by reciprocal multiply
    function automatic word_t div60(input word_t x);
        logic [2*WORD_W-1:0] p;
        p = {{WORD_W{1'b0}}, x} * {{WORD_W{1'b0}}, RECIP_60};
        return word_t'(p >> RECIP_60_SHIFT);
    endfunction

endpackage

/* rtl/dsm_ifs.sv */
// valid/ready channel interfaces for characters and results
interface dsm_char_if;
    import dsm_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface dsm_result_if;
    import dsm_pkg::*;

    logic  valid;
    logic  ready;
    word_t total_minutes;
    logic  parse_error;

    modport source (output valid, output total_minutes, output parse_error, input ready);
    modport sink   (input valid, input total_minutes, input parse_error, output ready);
endinterface

/* rtl/duration_string_to_minutes.sv */
// top level: iso 8601 duration string to whole minutes
// The block takes an ISO 8601 duration string ("P1DT2H30M") one ASCII byte
// per beat on chars, with last_char set on the final byte, and returns one
// beat on minutes per string: total_minutes = days*1440 + hours*60 + minutes
// + seconds/60, wrapping modulo 2^32, and parse_error when the string does not
// start with 'P', a counted designator has no digits, or a digit run exceeds
// 32 bits (total_minutes is 0 then). The first 'D', 'H' and 'S' count, the
// last 'M' counts only after a 'T', years, months and weeks are ignored.
// One byte is taken every cycle, back to back, also across string boundaries.
// When a string's last byte is taken, the byte is latched into the parse
// state and a snapshot of the scaled parts is registered; the snapshot's
// four parts are then added into the result register once it is free. The
// only limit on rate is backpressure on minutes; bytes keep being accepted
// while a result waits, until the snapshot stage also holds a string.
`include "duration_string_to_minutes_macros.svh"

module duration_string_to_minutes (
    input  logic                clk,
    input  logic                rst_n,
    dsm_char_if.sink            chars,
    dsm_result_if.source        minutes
);
    import dsm_pkg::*;

    // parse state
    logic      at_first_reg,      at_first_next;
    word_t     acc_reg,           acc_next;
    logic      run_has_digits_reg, run_has_digits_next;
    logic      run_overflowed_reg, run_overflowed_next;
    logic      seen_time_reg,     seen_time_next;
    word_t     day_min_reg,       day_min_next;
    logic      day_latched_reg,   day_latched_next;
    word_t     hour_min_reg,      hour_min_next;
    logic      hour_latched_reg,  hour_latched_next;
    word_t     sec_min_reg,       sec_min_next;
    logic      sec_latched_reg,   sec_latched_next;
    word_t     minute_count_reg,  minute_count_next;
    logic      minute_after_reg,  minute_after_next;
    logic      minute_bad_reg,    minute_bad_next;
    logic      sticky_err_reg,    sticky_err_next;

    // snapshot and result stages
    fin_t      fin_reg,           fin_next;
    logic      fin_valid_reg,     fin_valid_next;
    logic      out_valid_reg,     out_valid_next;
    word_t     out_total_reg,     out_total_next;
    logic      out_err_reg,       out_err_next;

    logic      beat;
    logic      out_free;
    logic      is_digit;
    logic      run_bad;
    acc_wide_t acc_sum;
    word_t     fin_sum;

    // handshake: result register frees when empty or taken, snapshot when it moves on
    assign out_free      = !out_valid_reg || minutes.ready;
    assign chars.ready   = !fin_valid_reg || out_free;
    assign beat          = chars.valid && chars.ready;

    assign minutes.valid         = out_valid_reg;
    assign minutes.total_minutes = out_total_reg;
    assign minutes.parse_error   = out_err_reg;

    // digit run: acc*10 + digit, overflow seen in the top four bits
    assign is_digit = (chars.character >= CH_0) && (chars.character <= CH_9);
    assign run_bad  = !run_has_digits_reg || run_overflowed_reg;
    assign acc_sum  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {{WORD_W{1'b0}}, chars.character[3:0]};

    always_comb
    begin
        at_first_next       = at_first_reg;
        acc_next            = acc_reg;
        run_has_digits_next = run_has_digits_reg;
        run_overflowed_next = run_overflowed_reg;
        seen_time_next      = seen_time_reg;
        day_min_next        = day_min_reg;
        day_latched_next    = day_latched_reg;
        hour_min_next       = hour_min_reg;
        hour_latched_next   = hour_latched_reg;
        sec_min_next        = sec_min_reg;
        sec_latched_next    = sec_latched_reg;
        minute_count_next   = minute_count_reg;
        minute_after_next   = minute_after_reg;
        minute_bad_next     = minute_bad_reg;
        sticky_err_next     = sticky_err_reg;
        fin_next            = fin_reg;

        if (beat)
        begin
            // a string must open with 'P'
            if (at_first_reg)
            begin
                if (chars.character != CH_P)
                begin
                    sticky_err_next = 1'b1;
                end
                at_first_next = 1'b0;
            end

            if (is_digit)
            begin
                acc_next            = acc_sum[WORD_W-1:0];
                run_has_digits_next = 1'b1;
                if (|acc_sum[WORD_W+3:WORD_W])
                begin
                    run_overflowed_next = 1'b1;
                end
            end
            else
            begin
                // designators latch the run directly before them, already scaled
                case (chars.character)
                    CH_D:
                    begin
                        if (!day_latched_reg)
                        begin
                            day_latched_next = 1'b1;
                            day_min_next     = times1440(acc_reg);
                            if (run_bad)
                            begin
                                sticky_err_next = 1'b1;
                            end
                        end
                    end
                    CH_H:
                    begin
                        if (!hour_latched_reg)
                        begin
                            hour_latched_next = 1'b1;
                            hour_min_next     = times60(acc_reg);
                            if (run_bad)
                            begin
                                sticky_err_next = 1'b1;
                            end
                        end
                    end
                    CH_S:
                    begin
                        if (!sec_latched_reg)
                        begin
                            sec_latched_next = 1'b1;
                            sec_min_next     = div60(acc_reg);
                            if (run_bad)
                            begin
                                sticky_err_next = 1'b1;
                            end
                        end
                    end
                    CH_M:
                    begin
                        // last 'M' wins; it only counts after a 'T'
                        minute_count_next = acc_reg;
                        minute_after_next = seen_time_reg;
                        minute_bad_next   = run_bad;
                    end
                    CH_T:
                    begin
                        seen_time_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                acc_next            = '0;
                run_has_digits_next = 1'b0;
                run_overflowed_next = 1'b0;
            end

            // end of string: snapshot the parts, then start over
            if (chars.last_char)
            begin
                fin_next.day_min  = day_min_next;
                fin_next.hour_min = hour_min_next;
                fin_next.minutes  = minute_after_next ? minute_count_next : '0;
                fin_next.sec_min  = sec_min_next;
                fin_next.err      = sticky_err_next || (minute_after_next && minute_bad_next);

                at_first_next       = 1'b1;
                acc_next            = '0;
                run_has_digits_next = 1'b0;
                run_overflowed_next = 1'b0;
                seen_time_next      = 1'b0;
                day_min_next        = '0;
                day_latched_next    = 1'b0;
                hour_min_next       = '0;
                hour_latched_next   = 1'b0;
                sec_min_next        = '0;
                sec_latched_next    = 1'b0;
                minute_count_next   = '0;
                minute_after_next   = 1'b0;
                minute_bad_next     = 1'b0;
                sticky_err_next     = 1'b0;
            end
        end
    end

    // snapshot stage and result register
    assign fin_sum = fin_reg.day_min + fin_reg.hour_min + fin_reg.minutes + fin_reg.sec_min;

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        out_valid_next = out_valid_reg;
        out_total_next = out_total_reg;
        out_err_next   = out_err_reg;

        if (out_free)
        begin
            out_valid_next = fin_valid_reg;
            out_total_next = fin_reg.err ? '0 : fin_sum;
            out_err_next   = fin_reg.err;
            fin_valid_next = 1'b0;
        end
        if (beat && chars.last_char)
        begin
            fin_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_first_reg       <= 1'b1;
            acc_reg            <= '0;
            run_has_digits_reg <= 1'b0;
            run_overflowed_reg <= 1'b0;
            seen_time_reg      <= 1'b0;
            day_min_reg        <= '0;
            day_latched_reg    <= 1'b0;
            hour_min_reg       <= '0;
            hour_latched_reg   <= 1'b0;
            sec_min_reg        <= '0;
            sec_latched_reg    <= 1'b0;
            minute_count_reg   <= '0;
            minute_after_reg   <= 1'b0;
            minute_bad_reg     <= 1'b0;
            sticky_err_reg     <= 1'b0;
            fin_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            at_first_reg       <= at_first_next;
            acc_reg            <= acc_next;
            run_has_digits_reg <= run_has_digits_next;
            run_overflowed_reg <= run_overflowed_next;
            seen_time_reg      <= seen_time_next;
            day_min_reg        <= day_min_next;
            day_latched_reg    <= day_latched_next;
            hour_min_reg       <= hour_min_next;
            hour_latched_reg   <= hour_latched_next;
            sec_min_reg        <= sec_min_next;
            sec_latched_reg    <= sec_latched_next;
            minute_count_reg   <= minute_count_next;
            minute_after_reg   <= minute_after_next;
            minute_bad_reg     <= minute_bad_next;
            sticky_err_reg     <= sticky_err_next;
            fin_valid_reg      <= fin_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fin_reg       <= fin_next;
        out_total_reg <= out_total_next;
        out_err_reg   <= out_err_next;
    end

    // checks
    `DSM_ASSERT_NOW(a_err_zero, out_valid_reg && out_err_reg, out_total_reg == '0)
    `DSM_ASSERT_NEXT(a_restart, beat && chars.last_char, at_first_reg && !sticky_err_reg)
    `DSM_ASSERT_NEXT(a_fin_load, beat && chars.last_char, fin_valid_reg)
    `DSM_ASSERT_NEXT(a_run_clear, beat && !is_digit, !run_has_digits_reg && acc_reg == '0)
    `DSM_ASSERT_NEXT(a_day_hold, beat && day_latched_reg && !chars.last_char, $stable(day_min_reg))

endmodule
